[design/mktg_pkg.sv]
// Shared package for the Morse keyer tone generator.
// Holds sizing constants, codes, channel and command types and Q1.15 helpers.
// No dependencies.
`default_nettype none

package mktg_pkg;

  // Sizing
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int SAMPLE_BITS = 16;
  localparam int SAMPLE_SHL  = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
  localparam int SAMPLE_SHR  = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
  localparam int SEG_W       = 18;
  localparam int CFG_AW      = 5;

  // Item function codes
  localparam logic [1:0] FUNC_ENQ   = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_ABORT = 2'd2;

  // Symbol codes
  localparam logic [1:0] SYM_DOT   = 2'd0;
  localparam logic [1:0] SYM_DASH  = 2'd1;
  localparam logic [1:0] SYM_SPACE = 2'd2;
  localparam logic [1:0] SYM_NONE  = 2'd3;

  // Segment kinds
  localparam logic [1:0] KIND_IDLE = 2'd0;
  localparam logic [1:0] KIND_TONE = 2'd1;
  localparam logic [1:0] KIND_SIL  = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_DOT_LEN  = 3'd0;
  localparam logic [2:0] REG_RAMP_LEN = 3'd1;
  localparam logic [2:0] REG_TONE_COS = 3'd2;
  localparam logic [2:0] REG_TONE_SIN = 3'd3;
  localparam logic [2:0] REG_RAMP_COS = 3'd4;
  localparam logic [2:0] REG_RAMP_SIN = 3'd5;

  // Q1.15 reset values
  localparam logic signed [15:0] Q15_ONE  = 16'sh7FFF;
  localparam logic signed [15:0] Q15_MIN  = 16'sh8000;
  localparam logic signed [15:0] Q15_ZERO = 16'sh0000;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] symbol;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          accepted;
    logic                          idle;
  } out_t;

  typedef struct packed {
    logic        [15:0] dot_length;
    logic        [12:0] ramp_length;
    logic signed [15:0] tone_cos;
    logic signed [15:0] tone_sin;
    logic signed [15:0] ramp_cos;
    logic signed [15:0] ramp_sin;
  } cfg_t;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_POP,
    OP_T0, OP_T1, OP_T2, OP_T3, OP_T4,
    OP_E0, OP_E1, OP_E2, OP_E3, OP_E4,
    OP_M0, OP_M1,
    OP_FIN,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic back;   // envelope phasor steps backward (falling ramp)
  } dp_cmd_t;

  typedef struct packed {
    logic active;        // a segment is playing with samples left
    logic tone;          // current segment is tone
    logic pos_lt_ramp;   // inside rising ramp
    logic left_le_ramp;  // inside falling ramp
  } dp_stat_t;

  // Round a Q3.30 sum to Q1.15 (add half, floor) and saturate
  function automatic logic signed [15:0] rnd_sat(input logic signed [32:0] a);
    logic signed [33:0] t;
    logic signed [18:0] q;
    t = 34'(a) + 34'sd16384;
    q = 19'(t >>> 15);
    if (q > 19'sd32767) begin
      return Q15_ONE;
    end else if (q < -19'sd32768) begin
      return Q15_MIN;
    end else begin
      return q[15:0];
    end
  endfunction

  // Raised-cosine gain (1 - re) / 2, saturated to 32767
  function automatic logic signed [15:0] env_amp(input logic signed [15:0] re);
    logic signed [17:0] d;
    logic signed [17:0] a;
    d = 18'sd32768 - 18'(re);
    a = d >>> 1;
    if (a[17:15] != 3'b000) begin
      return Q15_ONE;
    end else begin
      return a[15:0];
    end
  endfunction

  // Q1.15 to output sample width (shift left, or floor shift right)
  function automatic logic signed [SAMPLE_BITS-1:0] scale_sample(
    input logic signed [15:0] s
  );
    logic signed [47:0] w;
    w = 48'(s);
    w = (w <<< SAMPLE_SHL) >>> SAMPLE_SHR;
    return w[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

[design/mktg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mktg_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/mktg_regs.sv]
// APB-style configuration registers of the Morse keyer.
// Depends on mktg_pkg.
`default_nettype none

module mktg_regs
  import mktg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_DOT_LEN:  cfg_nxt.dot_length  = pwdata[15:0];
        REG_RAMP_LEN: cfg_nxt.ramp_length = pwdata[12:0];
        REG_TONE_COS: cfg_nxt.tone_cos    = pwdata[15:0];
        REG_TONE_SIN: cfg_nxt.tone_sin    = pwdata[15:0];
        REG_RAMP_COS: cfg_nxt.ramp_cos    = pwdata[15:0];
        REG_RAMP_SIN: cfg_nxt.ramp_sin    = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_length  <= 16'd4000;
      cfg_r.ramp_length <= 13'd400;
      cfg_r.tone_cos    <= Q15_ONE;
      cfg_r.tone_sin    <= Q15_ZERO;
      cfg_r.ramp_cos    <= Q15_ONE;
      cfg_r.ramp_sin    <= Q15_ZERO;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux, signed registers sign-extended
  always_comb begin
    unique case (idx)
      REG_DOT_LEN:  prdata = 32'(cfg_r.dot_length);
      REG_RAMP_LEN: prdata = 32'(cfg_r.ramp_length);
      REG_TONE_COS: prdata = 32'(cfg_r.tone_cos);
      REG_TONE_SIN: prdata = 32'(cfg_r.tone_sin);
      REG_RAMP_COS: prdata = 32'(cfg_r.ramp_cos);
      REG_RAMP_SIN: prdata = 32'(cfg_r.ramp_sin);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[design/mktg_dp.sv]
// Datapath of the Morse keyer: symbol FIFO, segment counters, tone and
// envelope phasors on one shared 16x16 multiplier, and the result register.
// Depends on mktg_pkg and mktg_ram.
`default_nettype none

module mktg_dp
  import mktg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  dp_cmd_t   cmd,
  input  in_t       in_data,
  input  cfg_t      cfg,
  output dp_stat_t  status,
  output out_t      out_data
);

  typedef struct packed {
    logic [1:0]       kind;
    logic [SEG_W-1:0] left;
  } seg_t;

  // Skip empty segments: tone -> silence -> idle
  function automatic seg_t settle(input seg_t s, input logic [15:0] dot);
    seg_t r;
    r = s;
    if (s.kind != KIND_IDLE && s.left == '0) begin
      if (s.kind == KIND_TONE && dot != '0) begin
        r.kind = KIND_SIL;
        r.left = SEG_W'(dot);
      end else begin
        r.kind = KIND_IDLE;
        r.left = '0;
      end
    end
    return r;
  endfunction

  // state
  logic [FIFO_AW-1:0]  head_r, head_nxt;
  logic [FIFO_CW-1:0]  count_r, count_nxt;
  seg_t                seg_r, seg_nxt;
  logic [SEG_W-1:0]    pos_r, pos_nxt;
  logic signed [15:0]  tone_re_r, tone_re_nxt, tone_im_r, tone_im_nxt;
  logic signed [15:0]  env_re_r, env_re_nxt, env_im_r, env_im_nxt;
  // payload
  logic signed [15:0]  tmp_r, tmp_nxt;
  logic signed [32:0]  acc_r, acc_nxt;
  logic signed [15:0]  sample_r, sample_nxt;
  logic                accepted_r, accepted_nxt;
  out_t                out_r, out_nxt;

  // FIFO storage
  logic               store_we;
  logic [FIFO_AW-1:0] store_waddr;
  logic [1:0]         store_rd;
  logic [FIFO_AW:0]   wsum;
  logic [FIFO_AW:0]   wwrap;

  // shared multiplier
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] prod;
  logic               acc_load, acc_add, acc_sub;

  logic [SEG_W-1:0]   triple_dot;
  logic [SEG_W-1:0]   left_dec;
  seg_t               seg_adv;

  mktg_ram #(
    .WIDTH(2),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(in_data.symbol),
    .raddr(head_r),
    .rdata(store_rd)
  );

  // tail address = (head + count) mod depth
  assign wsum        = (FIFO_AW+1)'(head_r) + (FIFO_AW+1)'(count_r);
  assign wwrap       = (wsum >= (FIFO_AW+1)'(FIFO_DEPTH)) ?
                       wsum - (FIFO_AW+1)'(FIFO_DEPTH) : wsum;
  assign store_waddr = wwrap[FIFO_AW-1:0];

  assign triple_dot  = SEG_W'(cfg.dot_length) + SEG_W'({cfg.dot_length, 1'b0});
  assign left_dec    = seg_r.left - 1'b1;

  // status to the controller
  assign status.active       = (seg_r.kind != KIND_IDLE) && (seg_r.left != '0);
  assign status.tone         = (seg_r.kind == KIND_TONE);
  assign status.pos_lt_ramp  = pos_r < SEG_W'(cfg.ramp_length);
  assign status.left_le_ramp = seg_r.left <= SEG_W'(cfg.ramp_length);

  // operand select for the shared multiplier
  always_comb begin
    mul_a    = tone_re_r;
    mul_b    = cfg.tone_cos;
    acc_load = 1'b0;
    acc_add  = 1'b0;
    acc_sub  = 1'b0;
    unique case (cmd.op)
      OP_T0: begin mul_a = tone_re_r; mul_b = cfg.tone_cos; acc_load = 1'b1; end
      OP_T1: begin mul_a = tone_im_r; mul_b = cfg.tone_sin; acc_sub  = 1'b1; end
      OP_T2: begin mul_a = tone_re_r; mul_b = cfg.tone_sin; acc_load = 1'b1; end
      OP_T3: begin mul_a = tone_im_r; mul_b = cfg.tone_cos; acc_add  = 1'b1; end
      OP_E0: begin mul_a = env_re_r;  mul_b = cfg.ramp_cos; acc_load = 1'b1; end
      OP_E1: begin
        mul_a   = env_im_r;
        mul_b   = cfg.ramp_sin;
        acc_add = cmd.back;
        acc_sub = !cmd.back;
      end
      OP_E2: begin mul_a = env_im_r;  mul_b = cfg.ramp_cos; acc_load = 1'b1; end
      OP_E3: begin
        mul_a   = env_re_r;
        mul_b   = cfg.ramp_sin;
        acc_add = !cmd.back;
        acc_sub = cmd.back;
      end
      OP_M0: begin mul_a = tone_im_r; mul_b = env_amp(env_re_r); acc_load = 1'b1; end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // accumulator
  always_comb begin
    acc_nxt = acc_r;
    if (acc_load) begin
      acc_nxt = 33'(prod);
    end else if (acc_add) begin
      acc_nxt = acc_r + 33'(prod);
    end else if (acc_sub) begin
      acc_nxt = acc_r - 33'(prod);
    end
  end

  // advance past a finished segment
  always_comb begin
    seg_adv.kind = KIND_IDLE;
    seg_adv.left = '0;
    if (seg_r.kind == KIND_TONE) begin
      seg_adv.kind = KIND_SIL;
      seg_adv.left = SEG_W'(cfg.dot_length);
    end
    seg_adv = settle(seg_adv, cfg.dot_length);
  end

  // micro-operation decode
  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    seg_nxt      = seg_r;
    pos_nxt      = pos_r;
    tone_re_nxt  = tone_re_r;
    tone_im_nxt  = tone_im_r;
    env_re_nxt   = env_re_r;
    env_im_nxt   = env_im_r;
    tmp_nxt      = tmp_r;
    sample_nxt   = sample_r;
    accepted_nxt = accepted_r;
    out_nxt      = out_r;
    store_we     = 1'b0;
    unique case (cmd.op)
      OP_ACCEPT: begin
        sample_nxt   = Q15_ZERO;
        accepted_nxt = 1'b0;
        unique case (in_data.func)
          FUNC_ENQ: begin
            if (in_data.symbol != SYM_NONE && count_r < FIFO_CW'(FIFO_DEPTH)) begin
              store_we     = 1'b1;
              count_nxt    = count_r + 1'b1;
              accepted_nxt = 1'b1;
            end
          end
          FUNC_ABORT: begin
            head_nxt    = '0;
            count_nxt   = '0;
            seg_nxt     = '0;
            pos_nxt     = '0;
            tone_re_nxt = Q15_ONE;
            tone_im_nxt = Q15_ZERO;
            env_re_nxt  = Q15_ONE;
            env_im_nxt  = Q15_ZERO;
          end
          default: ;
        endcase
      end
      // start the next queued symbol when nothing plays
      OP_POP: begin
        if (seg_r.kind == KIND_IDLE && count_r != '0) begin
          head_nxt    = (head_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt   = count_r - 1'b1;
          tone_re_nxt = Q15_ONE;
          tone_im_nxt = Q15_ZERO;
          env_re_nxt  = Q15_ONE;
          env_im_nxt  = Q15_ZERO;
          pos_nxt     = '0;
          unique case (store_rd)
            SYM_DOT:  begin seg_nxt.kind = KIND_TONE; seg_nxt.left = SEG_W'(cfg.dot_length); end
            SYM_DASH: begin seg_nxt.kind = KIND_TONE; seg_nxt.left = triple_dot; end
            default:  begin seg_nxt.kind = KIND_SIL;  seg_nxt.left = triple_dot; end
          endcase
          seg_nxt = settle(seg_nxt, cfg.dot_length);
        end
      end
      OP_T2: tmp_nxt = rnd_sat(acc_r);
      OP_T4: begin
        tone_re_nxt = tmp_r;
        tone_im_nxt = rnd_sat(acc_r);
        sample_nxt  = rnd_sat(acc_r);
      end
      OP_E2: tmp_nxt = rnd_sat(acc_r);
      OP_E4: begin
        env_re_nxt = tmp_r;
        env_im_nxt = rnd_sat(acc_r);
      end
      OP_M1: sample_nxt = rnd_sat(acc_r);
      // count down the segment, move on when it ends
      OP_FIN: begin
        if (seg_r.kind == KIND_TONE) begin
          pos_nxt = pos_r + 1'b1;
        end
        if (left_dec == '0) begin
          seg_nxt = seg_adv;
        end else begin
          seg_nxt.left = left_dec;
        end
      end
      OP_LOAD: begin
        out_nxt.sample   = scale_sample(sample_r);
        out_nxt.accepted = accepted_r;
        out_nxt.idle     = (seg_r.kind == KIND_IDLE) && (count_r == '0);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      seg_r     <= '0;
      pos_r     <= '0;
      tone_re_r <= Q15_ONE;
      tone_im_r <= Q15_ZERO;
      env_re_r  <= Q15_ONE;
      env_im_r  <= Q15_ZERO;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      seg_r     <= seg_nxt;
      pos_r     <= pos_nxt;
      tone_re_r <= tone_re_nxt;
      tone_im_r <= tone_im_nxt;
      env_re_r  <= env_re_nxt;
      env_im_r  <= env_im_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tmp_r      <= tmp_nxt;
    acc_r      <= acc_nxt;
    sample_r   <= sample_nxt;
    accepted_r <= accepted_nxt;
    out_r      <= out_nxt;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[design/mktg_ctrl.sv]
// Controller of the Morse keyer: handshakes and the micro-operation sequence
// that drives the datapath. Depends on mktg_pkg.
`default_nettype none

module mktg_ctrl
  import mktg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_func,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  dp_stat_t        status,
  output dp_cmd_t         cmd
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_POP    = 17'h00002,
    S_DECIDE = 17'h00004,
    S_T0     = 17'h00008,
    S_T1     = 17'h00010,
    S_T2     = 17'h00020,
    S_T3     = 17'h00040,
    S_T4     = 17'h00080,
    S_E0     = 17'h00100,
    S_E1     = 17'h00200,
    S_E2     = 17'h00400,
    S_E3     = 17'h00800,
    S_E4     = 17'h01000,
    S_M0     = 17'h02000,
    S_M1     = 17'h04000,
    S_FIN    = 17'h08000,
    S_RES    = 17'h10000
  } state_t;

  state_t state_r, state_nxt;
  logic   dir_r, dir_nxt;          // 1: falling ramp
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    dir_nxt       = dir_r;
    cmd.op        = OP_NONE;
    cmd.back      = dir_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = (in_func == FUNC_TICK) ? S_POP : S_RES;
        end
      end
      S_POP: begin
        cmd.op    = OP_POP;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (!status.active) begin
          state_nxt = S_RES;
        end else if (status.tone) begin
          state_nxt = S_T0;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_T0: begin cmd.op = OP_T0; state_nxt = S_T1; end
      S_T1: begin cmd.op = OP_T1; state_nxt = S_T2; end
      S_T2: begin cmd.op = OP_T2; state_nxt = S_T3; end
      S_T3: begin cmd.op = OP_T3; state_nxt = S_T4; end
      // rising ramp wins over falling ramp
      S_T4: begin
        cmd.op = OP_T4;
        if (status.pos_lt_ramp) begin
          dir_nxt   = 1'b0;
          state_nxt = S_M0;
        end else if (status.left_le_ramp) begin
          dir_nxt   = 1'b1;
          state_nxt = S_E0;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_E0: begin cmd.op = OP_E0; state_nxt = S_E1; end
      S_E1: begin cmd.op = OP_E1; state_nxt = S_E2; end
      S_E2: begin cmd.op = OP_E2; state_nxt = S_E3; end
      S_E3: begin cmd.op = OP_E3; state_nxt = S_E4; end
      S_E4: begin
        cmd.op    = OP_E4;
        state_nxt = dir_r ? S_M0 : S_FIN;
      end
      S_M0: begin cmd.op = OP_M0; state_nxt = S_M1; end
      S_M1: begin
        cmd.op    = OP_M1;
        state_nxt = dir_r ? S_FIN : S_E0;
      end
      S_FIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_RES;
      end
      // result register must be free before loading
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("controller stayed ready after a transaction");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |=> out_valid)
    else $error("result load did not raise out_valid");

  a_res_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && out_valid_r && !out_ready) |=>
      (state_r == S_RES && out_valid_r))
    else $error("result overwritten while still pending");

  a_tone_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T0) |-> (status.tone && status.active))
    else $error("tone sequence entered without a tone segment");

endmodule

`default_nettype wire

[design/morse_keyer_tone_generator.sv]
// Morse keyer tone generator, top level. One item in flight at a time.
// Enqueue/abort go from accept straight to the result load. A tick pops the FIFO
// when nothing plays; for a tone segment it rotates the tone phasor (and, in a ramp,
// the envelope phasor and gain) on the single shared 16x16 multiplier (4 products
// per phasor rotation, 1 for the envelope gain); it counts down an active segment.
// Reset: synchronous active-low rst_n; FIFO storage is not cleared (count zero).
`default_nettype none

module morse_keyer_tone_generator
  import mktg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_t                   out_data,
  // configuration port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t status;

  // configuration registers
  mktg_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .cfg    (cfg)
  );

  // sequencer
  mktg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // FIFO, counters, phasors, result register
  mktg_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .cfg     (cfg),
    .status  (status),
    .out_data(out_data)
  );

endmodule

`default_nettype wire
